FILE: rtl/cle_pkg.sv
// shared constants, codes and control types for the cursor list engine
package cle_pkg;

   localparam int NODES   = 1024;
   localparam int IDX_W   = $clog2(NODES);
   localparam int VAL_W   = 32;
   localparam int CNT_W   = 10;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 56;

   localparam logic [IDX_W:0] FRESH_LIMIT = (IDX_W + 1)'(NODES);
   localparam logic [IDX_W:0] FRESH_FIRST = (IDX_W + 1)'(1);
   localparam logic [IDX_W-1:0] HEADER_NODE = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_NEXT   = 3'd2,
      CMD_PREV   = 3'd3,
      CMD_HOME   = 3'd4,
      CMD_COUNT  = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INS_FREE,
      ST_INS_CUR,
      ST_INS_WR,
      ST_INS_LINK,
      ST_REM_RD,
      ST_REM_NXT,
      ST_REM_WR1,
      ST_REM_WR2,
      ST_NEXT_RD,
      ST_NEXT_UPD,
      ST_PREV_START,
      ST_PREV_WALK,
      ST_HOME,
      ST_CNT_START,
      ST_CNT_WALK,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_INS_START,
      OP_INS_CUR,
      OP_INS_WR,
      OP_INS_LINK,
      OP_REM_RD,
      OP_REM_NXT,
      OP_REM_WR1,
      OP_REM_WR2,
      OP_NEXT_RD,
      OP_NEXT_UPD,
      OP_PREV_START,
      OP_PREV_STEP,
      OP_HOME,
      OP_CNT_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic link_null;
      logic cursor_header;
      logic cursor_tail;
      logic walk_stop;
   } dp_stat_type;

endpackage

FILE: rtl/cle_datapath.sv
// node memories, list pointers, counters and result registers
module cle_datapath
   import cle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic [VAL_W-1:0]   req_value,
   output dp_stat_type        stat,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [VAL_W-1:0]   rsp_removed_value,
   output logic [CNT_W-1:0]   rsp_match_count,
   output logic [CNT_W-1:0]   rsp_list_length
);

   logic [VAL_W-1:0] node_values_mem [NODES];
   logic [IDX_W-1:0] node_links_mem  [NODES];

   logic [IDX_W-1:0]  head_link_ff, head_link_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [IDX_W-1:0]  free_head_ff, free_head_in;
   logic [IDX_W:0]    fresh_ff, fresh_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [IDX_W-1:0]  node_ff, node_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0]  removed_ff, removed_in;
   logic [CNT_W-1:0]  match_ff, match_in;
   logic              use_free_ff, use_free_in;
   logic              vpend_ff, vpend_in;
   logic              rd_hdr_ff;
   logic [IDX_W-1:0]  link_rd_ff;
   logic [VAL_W-1:0]  val_rd_ff;

   logic [STAT_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]  rsp_removed_ff;
   logic [CNT_W-1:0]  rsp_match_ff;
   logic [CNT_W-1:0]  rsp_length_ff;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              lk_we;
   logic [IDX_W-1:0]  lk_waddr;
   logic [IDX_W-1:0]  lk_wdata;
   logic              vl_we;
   logic [IDX_W-1:0]  link_q;
   logic              full;

   // the header link lives in a register so the memory needs no clearing
   assign link_q = rd_hdr_ff ? head_link_ff : link_rd_ff;
   assign full   = (free_head_ff == HEADER_NODE) && (fresh_ff == FRESH_LIMIT);

   assign stat.full          = full;
   assign stat.link_null     = (link_q == HEADER_NODE);
   assign stat.cursor_header = (cursor_ff == HEADER_NODE);
   assign stat.cursor_tail   = (cursor_ff == tail_ff);
   assign stat.walk_stop     = (link_q == cursor_ff) || (link_q == HEADER_NODE);

   always_comb begin
      cursor_in    = cursor_ff;
      tail_in      = tail_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      count_in     = count_ff;
      value_in     = value_ff;
      node_in      = node_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      match_in     = match_ff;
      use_free_in  = use_free_ff;
      vpend_in     = vpend_ff;
      rd_en        = 1'b0;
      rd_addr      = HEADER_NODE;
      lk_we        = 1'b0;
      lk_waddr     = HEADER_NODE;
      lk_wdata     = HEADER_NODE;
      vl_we        = 1'b0;
      case (cmd.op)
         OP_LOAD: begin
            value_in   = req_value;
            status_in  = STAT_OK;
            removed_in = '0;
            match_in   = '0;
            vpend_in   = 1'b0;
         end
         OP_INS_START: begin
            if (free_head_ff != HEADER_NODE) begin
               node_in     = free_head_ff;
               use_free_in = 1'b1;
               rd_en       = 1'b1;
               rd_addr     = free_head_ff;
            end else if (!full) begin
               node_in     = fresh_ff[IDX_W-1:0];
               use_free_in = 1'b0;
               fresh_in    = fresh_ff + FRESH_FIRST;
            end else begin
               status_in = STAT_FULL;
            end
         end
         OP_INS_CUR: begin
            if (use_free_ff) begin
               free_head_in = link_q;
            end
            rd_en   = 1'b1;
            rd_addr = cursor_ff;
         end
         OP_INS_WR: begin
            lk_we    = 1'b1;
            lk_waddr = node_ff;
            lk_wdata = link_q;
            vl_we    = 1'b1;
            if (tail_ff == cursor_ff) begin
               tail_in = node_ff;
            end
            count_in = count_ff + CNT_W'(1);
         end
         OP_INS_LINK: begin
            lk_we    = 1'b1;
            lk_waddr = cursor_ff;
            lk_wdata = node_ff;
         end
         OP_REM_RD, OP_NEXT_RD: begin
            rd_en   = 1'b1;
            rd_addr = cursor_ff;
         end
         OP_REM_NXT: begin
            node_in = link_q;
            if (link_q == HEADER_NODE) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = link_q;
            end
         end
         OP_REM_WR1: begin
            removed_in = val_rd_ff;
            lk_we      = 1'b1;
            lk_waddr   = cursor_ff;
            lk_wdata   = link_q;
            if (tail_ff == node_ff) begin
               tail_in = cursor_ff;
            end
         end
         OP_REM_WR2: begin
            lk_we        = 1'b1;
            lk_waddr     = node_ff;
            lk_wdata     = free_head_ff;
            free_head_in = node_ff;
            count_in     = count_ff - CNT_W'(1);
         end
         OP_NEXT_UPD: begin
            cursor_in = link_q;
         end
         OP_PREV_START: begin
            node_in  = HEADER_NODE;
            rd_en    = 1'b1;
            rd_addr  = HEADER_NODE;
            vpend_in = 1'b0;
         end
         OP_PREV_STEP: begin
            if (link_q == cursor_ff) begin
               cursor_in = node_ff;
            end else if (link_q != HEADER_NODE) begin
               node_in = link_q;
               rd_en   = 1'b1;
               rd_addr = link_q;
            end
         end
         OP_HOME: begin
            cursor_in = HEADER_NODE;
         end
         OP_CNT_STEP: begin
            // compare the value fetched last cycle, fetch the next node
            if (vpend_ff && (val_rd_ff == value_ff)) begin
               match_in = match_ff + CNT_W'(1);
            end
            if (link_q != HEADER_NODE) begin
               rd_en    = 1'b1;
               rd_addr  = link_q;
               vpend_in = 1'b1;
            end else begin
               vpend_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      head_link_in = head_link_ff;
      if (lk_we && (lk_waddr == HEADER_NODE)) begin
         head_link_in = lk_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_we && (lk_waddr != HEADER_NODE)) begin
         node_links_mem[lk_waddr] <= lk_wdata;
      end
      if (vl_we) begin
         node_values_mem[node_ff] <= value_ff;
      end
      if (rd_en) begin
         link_rd_ff <= node_links_mem[rd_addr];
         val_rd_ff  <= node_values_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_link_ff <= HEADER_NODE;
         cursor_ff    <= HEADER_NODE;
         tail_ff      <= HEADER_NODE;
         free_head_ff <= HEADER_NODE;
         fresh_ff     <= FRESH_FIRST;
         count_ff     <= '0;
         use_free_ff  <= 1'b0;
         vpend_ff     <= 1'b0;
         rd_hdr_ff    <= 1'b0;
      end else begin
         head_link_ff <= head_link_in;
         cursor_ff    <= cursor_in;
         tail_ff      <= tail_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         use_free_ff  <= use_free_in;
         vpend_ff     <= vpend_in;
         if (rd_en) begin
            rd_hdr_ff <= (rd_addr == HEADER_NODE);
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      node_ff    <= node_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      match_ff   <= match_in;
      if (cmd.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_match_ff   <= match_ff;
         rsp_length_ff  <= count_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_match_count   = rsp_match_ff;
   assign rsp_list_length   = rsp_length_ff;

endmodule

FILE: rtl/cle_controller.sv
// command sequencer and result handshake for the cursor list engine
module cle_controller
   import cle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [CMD_W-1:0]  req_cmd,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  dp_stat_type       stat,
   output dp_cmd_type        cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  CMD_INSERT: state_in = ST_INS_FREE;
                  CMD_REMOVE: state_in = ST_REM_RD;
                  CMD_NEXT:   state_in = ST_NEXT_RD;
                  CMD_PREV:   state_in = ST_PREV_START;
                  CMD_HOME:   state_in = ST_HOME;
                  CMD_COUNT:  state_in = ST_CNT_START;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_FREE:   state_in = stat.full ? ST_DONE : ST_INS_CUR;
         ST_INS_CUR:    state_in = ST_INS_WR;
         ST_INS_WR:     state_in = ST_INS_LINK;
         ST_INS_LINK:   state_in = ST_DONE;
         ST_REM_RD:     state_in = ST_REM_NXT;
         ST_REM_NXT:    state_in = stat.link_null ? ST_DONE : ST_REM_WR1;
         ST_REM_WR1:    state_in = ST_REM_WR2;
         ST_REM_WR2:    state_in = ST_DONE;
         ST_NEXT_RD:    state_in = stat.cursor_tail ? ST_DONE : ST_NEXT_UPD;
         ST_NEXT_UPD:   state_in = ST_DONE;
         ST_PREV_START: state_in = stat.cursor_header ? ST_DONE : ST_PREV_WALK;
         ST_PREV_WALK:  state_in = stat.walk_stop ? ST_DONE : ST_PREV_WALK;
         ST_HOME:       state_in = ST_DONE;
         ST_CNT_START:  state_in = ST_CNT_WALK;
         ST_CNT_WALK:   state_in = stat.link_null ? ST_DONE : ST_CNT_WALK;
         ST_DONE:       state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NOP;
      cmd.rsp_load = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
            end
         end
         ST_INS_FREE: cmd.op = OP_INS_START;
         ST_INS_CUR:  cmd.op = OP_INS_CUR;
         ST_INS_WR:   cmd.op = OP_INS_WR;
         ST_INS_LINK: cmd.op = OP_INS_LINK;
         ST_REM_RD:   cmd.op = OP_REM_RD;
         ST_REM_NXT:  cmd.op = OP_REM_NXT;
         ST_REM_WR1:  cmd.op = OP_REM_WR1;
         ST_REM_WR2:  cmd.op = OP_REM_WR2;
         ST_NEXT_RD:  cmd.op = stat.cursor_tail ? OP_NOP : OP_NEXT_RD;
         ST_NEXT_UPD: cmd.op = OP_NEXT_UPD;
         ST_PREV_START: cmd.op = stat.cursor_header ? OP_NOP : OP_PREV_START;
         ST_PREV_WALK:  cmd.op = OP_PREV_STEP;
         ST_HOME:       cmd.op = OP_HOME;
         // the first walk step reads the header link
         ST_CNT_START:  cmd.op = OP_PREV_START;
         ST_CNT_WALK:   cmd.op = OP_CNT_STEP;
         ST_DONE:       cmd.rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/cursor_list_engine_top.sv
// a full insert stops after the free slot check; a remove with nothing after the cursor
// stops after reading the cursor link; next at the tail and unused codes go to the result
// prev walks from the header to the cursor, count the whole list; one node read per cycle
// one transaction in flight; the next request is taken in the cycle its result turns valid
// a stalled result holds the engine; the node memories have one read and one write port
// reset is synchronous active high, clears pointers and counters; no memory clearing pass
module cursor_list_engine_top
   import cle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // cmd[2:0], value[34:3], zero[39:35]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // status[1:0], removed_value[33:2],
                                        // match_count[43:34], list_length[53:44], zero[55:54]
);

   dp_cmd_type        dp_cmd;
   dp_stat_type       dp_stat;
   logic [STAT_W-1:0] rsp_status;
   logic [VAL_W-1:0]  rsp_removed_value;
   logic [CNT_W-1:0]  rsp_match_count;
   logic [CNT_W-1:0]  rsp_list_length;

   cle_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tdata[CMD_W-1:0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   cle_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .req_value         (req_tdata[CMD_W +: VAL_W]),
      .stat              (dp_stat),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_match_count   (rsp_match_count),
      .rsp_list_length   (rsp_list_length)
   );

   assign rsp_tdata = {(RSP_W - STAT_W - VAL_W - 2 * CNT_W)'(0), rsp_list_length,
                       rsp_match_count, rsp_removed_value, rsp_status};

endmodule

FILE: rtl/cle_checker.sv
// port-level assertions for the cursor list engine, bound to the top level
module cle_checker
   import cle_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one transaction at a time: no second request right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a failed command never returns a removed value
   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != 2'd0) |-> rsp_tdata[33:2] == '0)
      else $error("removed value on failed command");

   // status code three is never produced and the pad bits stay zero
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[55:54] == 2'd0))
      else $error("bad status or pad bits");

endmodule

bind cursor_list_engine_top cle_checker u_cle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
